>>> src/fpd_pkg.sv
package fpd_pkg;

	// nominal 1 g in accelerometer units
	localparam int unsigned ONE_G = 2048;

	// field and datapath widths
	localparam int unsigned ACC_W  = 16;
	localparam int unsigned ALT_W  = 24;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned CFG_W  = 16;
	localparam int unsigned SQ_W   = 31;   // square of a 16-bit signed value
	localparam int unsigned MAG_W  = 32;   // sum of three squares
	localparam int unsigned BND_W  = 17;   // ONE_G plus or minus tolerance
	localparam int unsigned BSQ_W  = 34;   // square of a bound

	// stream and register port widths
	localparam int unsigned S_DATA_W = 112;
	localparam int unsigned M_DATA_W = 8;
	localparam int unsigned ADDR_W   = 4;
	localparam int unsigned PDATA_W  = 32;

	// register indexes
	typedef enum logic [1:0] {
		REG_LAUNCH_THRESHOLD  = 2'd0,
		REG_APOGEE_DELAY      = 2'd1,
		REG_LANDING_TOLERANCE = 2'd2,
		REG_LANDING_HOLD      = 2'd3
	} fpd_reg_t;

	// register reset values
	localparam logic [CFG_W-1:0] RST_LAUNCH_THRESHOLD  = 16'd6144;
	localparam logic [CFG_W-1:0] RST_APOGEE_DELAY      = 16'd1000;
	localparam logic [CFG_W-1:0] RST_LANDING_TOLERANCE = 16'd205;
	localparam logic [CFG_W-1:0] RST_LANDING_HOLD      = 16'd5000;

	// external phase codes
	localparam logic [2:0] CODE_STANDBY = 3'd0;
	localparam logic [2:0] CODE_ARMED   = 3'd1;
	localparam logic [2:0] CODE_FLIGHT  = 3'd2;
	localparam logic [2:0] CODE_APOGEE  = 3'd3;
	localparam logic [2:0] CODE_DESCENT = 3'd4;
	localparam logic [2:0] CODE_GROUND  = 3'd5;

	// one-hot phase state
	typedef enum logic [5:0] {
		PH_STANDBY = 6'b000001,
		PH_ARMED   = 6'b000010,
		PH_FLIGHT  = 6'b000100,
		PH_APOGEE  = 6'b001000,
		PH_DESCENT = 6'b010000,
		PH_GROUND  = 6'b100000
	} fpd_phase_t;

	// input request as taken from the stream
	typedef struct packed {
		logic                     action;
		logic [2:0]               new_phase;
		logic signed [ACC_W-1:0]  accel_x;
		logic signed [ACC_W-1:0]  accel_y;
		logic signed [ACC_W-1:0]  accel_z;
		logic signed [ALT_W-1:0]  altitude_cm;
		logic [TIME_W-1:0]        now_ms;
	} fpd_in_t;

	// squared thresholds derived from the registers
	typedef struct packed {
		logic [MAG_W-1:0] launch_sq;
		logic [BSQ_W-1:0] hi_sq;
		logic [BSQ_W-1:0] lo_sq;
		logic             lo_en;
	} fpd_thr_t;

	// timing registers for the phase tracker
	typedef struct packed {
		logic [CFG_W-1:0] apogee_delay;
		logic [CFG_W-1:0] landing_hold;
	} fpd_tim_t;

	// classified request handed to the phase tracker
	typedef struct packed {
		logic                     action;
		logic [2:0]               new_phase;
		logic signed [ALT_W-1:0]  altitude_cm;
		logic [TIME_W-1:0]        now_ms;
		logic                     launch_hit;
		logic                     near_one_g;
	} fpd_cls_t;

	// binary phase code to one-hot state
	function automatic fpd_phase_t phase_decode(input logic [2:0] code);
		fpd_phase_t ph;
		case (code)
			CODE_STANDBY: ph = PH_STANDBY;
			CODE_ARMED:   ph = PH_ARMED;
			CODE_FLIGHT:  ph = PH_FLIGHT;
			CODE_APOGEE:  ph = PH_APOGEE;
			CODE_DESCENT: ph = PH_DESCENT;
			CODE_GROUND:  ph = PH_GROUND;
			default:      ph = PH_STANDBY;
		endcase
		return ph;
	endfunction

	// one-hot state to binary phase code
	function automatic logic [2:0] phase_encode(input fpd_phase_t ph);
		logic [2:0] code;
		case (ph)
			PH_STANDBY: code = CODE_STANDBY;
			PH_ARMED:   code = CODE_ARMED;
			PH_FLIGHT:  code = CODE_FLIGHT;
			PH_APOGEE:  code = CODE_APOGEE;
			PH_DESCENT: code = CODE_DESCENT;
			PH_GROUND:  code = CODE_GROUND;
			default:    code = CODE_STANDBY;
		endcase
		return code;
	endfunction

endpackage

>>> src/flight_phase_detector_top.sv
// flight phase detector
// slave stream takes one request per accepted beat: s_tuser is the action
// (0 sensor sample, 1 forced phase write), s_tdata carries the forced phase,
// the three acceleration axes, the altitude and the millisecond timestamp.
// master stream returns one result per request: the phase after that request
// and the apogee-seen flag, in request order.
// thresholds are set through the register port; write them only while no
// request is in flight.
// from input acceptance to m_tvalid, the request lands in the input register at
// acceptance, then passes the axis-square and magnitude-compare registers before
// the phase update writes the result register that drives m_tvalid.
// throughput is one request per cycle while m_tready keeps the result register
// draining, set by the phase update that closes the loop on the tracker state.
// each stage holds its request when the next is full, so a stalled receiver
// fills the pipeline and then drops s_tready; up to four requests are held.
// reset clears the phase to standby, drops all latches and timers, empties
// the pipeline and restores the register defaults.
module flight_phase_detector_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// new_phase, accel_x, accel_y, accel_z, altitude_cm, now_ms, zero pad
	input  logic [fpd_pkg::S_DATA_W-1:0]  s_tdata,
	// action
	input  logic                          s_tuser,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// phase, apogee_seen, zero pad
	output logic [fpd_pkg::M_DATA_W-1:0]  m_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fpd_pkg::ADDR_W-1:0]    paddr,
	input  logic [fpd_pkg::PDATA_W-1:0]   pwdata,
	output logic [fpd_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import fpd_pkg::*;

	fpd_in_t    in_item;
	fpd_thr_t   thr;
	fpd_tim_t   tim;
	logic       cls_valid;
	logic       cls_ready;
	fpd_cls_t   cls_item;
	logic [2:0] out_phase;
	logic       out_apogee_seen;

	// unpack the request
	assign in_item.action      = s_tuser;
	assign in_item.new_phase   = s_tdata[2:0];
	assign in_item.accel_x     = s_tdata[18:3];
	assign in_item.accel_y     = s_tdata[34:19];
	assign in_item.accel_z     = s_tdata[50:35];
	assign in_item.altitude_cm = s_tdata[74:51];
	assign in_item.now_ms      = s_tdata[106:75];

	fpd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.thr     (thr),
		.tim     (tim)
	);

	fpd_mag u_mag (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (in_item),
		.thr       (thr),
		.cls_valid (cls_valid),
		.cls_ready (cls_ready),
		.cls_item  (cls_item)
	);

	fpd_track u_track (
		.clk             (clk),
		.arst_n          (arst_n),
		.cls_valid       (cls_valid),
		.cls_ready       (cls_ready),
		.cls_item        (cls_item),
		.tim             (tim),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_phase       (out_phase),
		.out_apogee_seen (out_apogee_seen)
	);

	// pack the result
	assign m_tdata = {4'b0000, out_apogee_seen, out_phase};

endmodule

>>> src/fpd_cfg.sv
module fpd_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fpd_pkg::ADDR_W-1:0]    paddr,
	input  logic [fpd_pkg::PDATA_W-1:0]   pwdata,
	output logic [fpd_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output fpd_pkg::fpd_thr_t             thr,
	output fpd_pkg::fpd_tim_t             tim
);
	import fpd_pkg::*;

	logic [CFG_W-1:0] launch_threshold_q;
	logic [CFG_W-1:0] apogee_delay_q;
	logic [CFG_W-1:0] landing_tolerance_q;
	logic [CFG_W-1:0] landing_hold_q;
	fpd_reg_t         reg_idx;
	logic             wr_en;
	logic [BND_W-1:0] hi_bound;
	logic [BND_W-1:0] lo_bound;
	fpd_thr_t         thr_q;

	assign pready  = 1'b1;
	assign reg_idx = fpd_reg_t'(paddr[ADDR_W-1:2]);
	assign wr_en   = psel & penable & pwrite & pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_threshold_q  <= RST_LAUNCH_THRESHOLD;
			apogee_delay_q      <= RST_APOGEE_DELAY;
			landing_tolerance_q <= RST_LANDING_TOLERANCE;
			landing_hold_q      <= RST_LANDING_HOLD;
		end else if (wr_en) begin
			case (reg_idx)
				REG_LAUNCH_THRESHOLD:  launch_threshold_q  <= pwdata[CFG_W-1:0];
				REG_APOGEE_DELAY:      apogee_delay_q      <= pwdata[CFG_W-1:0];
				REG_LANDING_TOLERANCE: landing_tolerance_q <= pwdata[CFG_W-1:0];
				REG_LANDING_HOLD:      landing_hold_q      <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (reg_idx)
			REG_LAUNCH_THRESHOLD:  prdata = PDATA_W'(launch_threshold_q);
			REG_APOGEE_DELAY:      prdata = PDATA_W'(apogee_delay_q);
			REG_LANDING_TOLERANCE: prdata = PDATA_W'(landing_tolerance_q);
			REG_LANDING_HOLD:      prdata = PDATA_W'(landing_hold_q);
			default:               prdata = '0;
		endcase
	end

	// bounds around 1 g
	assign hi_bound = BND_W'(ONE_G) + BND_W'(landing_tolerance_q);
	assign lo_bound = BND_W'(ONE_G) - BND_W'(landing_tolerance_q);

	// squared thresholds, recomputed every cycle from the registers
	always_ff @(posedge clk) begin
		thr_q.launch_sq <= MAG_W'(launch_threshold_q) * MAG_W'(launch_threshold_q);
		thr_q.hi_sq     <= BSQ_W'(hi_bound) * BSQ_W'(hi_bound);
		thr_q.lo_sq     <= BSQ_W'(lo_bound) * BSQ_W'(lo_bound);
		thr_q.lo_en     <= (BND_W'(landing_tolerance_q) <= BND_W'(ONE_G));
	end

	assign thr              = thr_q;
	assign tim.apogee_delay = apogee_delay_q;
	assign tim.landing_hold = landing_hold_q;

endmodule

>>> src/fpd_mag.sv
module fpd_mag (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  fpd_pkg::fpd_in_t   in_item,
	input  fpd_pkg::fpd_thr_t  thr,
	output logic               cls_valid,
	input  logic               cls_ready,
	output fpd_pkg::fpd_cls_t  cls_item
);
	import fpd_pkg::*;

	logic                 valid_s1, valid_s2, valid_s3;
	logic                 ready_s1, ready_s2, ready_s3;
	fpd_in_t              item_s1;
	fpd_in_t              item_s2;
	logic [SQ_W-1:0]      sq_x_s2, sq_y_s2, sq_z_s2;
	logic signed [2*ACC_W-1:0] prod_x, prod_y, prod_z;
	logic [MAG_W-1:0]     mag_sq;
	fpd_cls_t             cls_s3;

	// per-stage ready so bubbles collapse
	assign ready_s3 = !valid_s3 || cls_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) item_s1 <= in_item;
	end

	// axis squares
	assign prod_x = (2*ACC_W)'(item_s1.accel_x) * (2*ACC_W)'(item_s1.accel_x);
	assign prod_y = (2*ACC_W)'(item_s1.accel_y) * (2*ACC_W)'(item_s1.accel_y);
	assign prod_z = (2*ACC_W)'(item_s1.accel_z) * (2*ACC_W)'(item_s1.accel_z);

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			item_s2 <= item_s1;
			sq_x_s2 <= prod_x[SQ_W-1:0];
			sq_y_s2 <= prod_y[SQ_W-1:0];
			sq_z_s2 <= prod_z[SQ_W-1:0];
		end
	end

	// magnitude and threshold compares
	assign mag_sq = MAG_W'(sq_x_s2) + MAG_W'(sq_y_s2) + MAG_W'(sq_z_s2);

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			cls_s3.action      <= item_s2.action;
			cls_s3.new_phase   <= item_s2.new_phase;
			cls_s3.altitude_cm <= item_s2.altitude_cm;
			cls_s3.now_ms      <= item_s2.now_ms;
			cls_s3.launch_hit  <= (mag_sq > thr.launch_sq);
			cls_s3.near_one_g  <= (BSQ_W'(mag_sq) < thr.hi_sq) &&
				(!thr.lo_en || (BSQ_W'(mag_sq) > thr.lo_sq));
		end
	end

	assign cls_valid = valid_s3;
	assign cls_item  = cls_s3;

endmodule

>>> src/fpd_track.sv
module fpd_track (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cls_valid,
	output logic               cls_ready,
	input  fpd_pkg::fpd_cls_t  cls_item,
	input  fpd_pkg::fpd_tim_t  tim,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         out_phase,
	output logic               out_apogee_seen
);
	import fpd_pkg::*;

	fpd_phase_t               phase_q, phase_nx;
	logic signed [ALT_W-1:0]  last_alt_q;
	logic                     alt_valid_q;
	logic                     apo_latched_q, apo_latched_nx;
	logic [TIME_W-1:0]        apo_time_q, apo_time_nx;
	logic                     stable_active_q, stable_active_nx;
	logic [TIME_W-1:0]        stable_start_q, stable_start_nx;
	logic signed [ALT_W-1:0]  prev_alt;
	logic                     alt_drop;
	logic [TIME_W-1:0]        since_apo;
	logic [TIME_W-1:0]        since_stable;
	logic                     apo_elapsed;
	logic                     hold_elapsed;
	logic                     take;
	logic                     out_valid_q;
	logic [2:0]               out_phase_q;
	logic                     out_apogee_q;

	assign cls_ready = !out_valid_q || out_ready;
	assign take      = cls_valid && cls_ready;

	// altitude drop and elapsed-time tests
	assign prev_alt     = alt_valid_q ? last_alt_q : cls_item.altitude_cm;
	assign alt_drop     = (cls_item.altitude_cm < prev_alt) && !apo_latched_q;
	assign since_apo    = cls_item.now_ms - apo_time_q;
	assign apo_elapsed  = since_apo > TIME_W'(tim.apogee_delay);
	assign since_stable = stable_active_q ? (cls_item.now_ms - stable_start_q) : '0;
	assign hold_elapsed = since_stable > TIME_W'(tim.landing_hold);

	// next phase and latches
	always_comb begin
		phase_nx         = phase_q;
		apo_latched_nx   = apo_latched_q;
		apo_time_nx      = apo_time_q;
		stable_active_nx = stable_active_q;
		stable_start_nx  = stable_start_q;
		if (cls_item.action) begin
			if (cls_item.new_phase inside {[CODE_STANDBY:CODE_GROUND]})
				phase_nx = phase_decode(cls_item.new_phase);
		end else begin
			case (phase_q)
				PH_ARMED: begin
					if (cls_item.launch_hit) phase_nx = PH_FLIGHT;
				end
				PH_FLIGHT: begin
					if (alt_drop) begin
						apo_latched_nx = 1'b1;
						apo_time_nx    = cls_item.now_ms;
					end
					// a drop on this sample gives zero elapsed time
					if (apo_latched_q && apo_elapsed) phase_nx = PH_APOGEE;
				end
				PH_APOGEE: begin
					if (apo_elapsed) phase_nx = PH_DESCENT;
				end
				PH_DESCENT: begin
					if (cls_item.near_one_g) begin
						if (!stable_active_q) begin
							stable_active_nx = 1'b1;
							stable_start_nx  = cls_item.now_ms;
						end
						if (hold_elapsed) phase_nx = PH_GROUND;
					end else begin
						stable_active_nx = 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_STANDBY;
			last_alt_q      <= '0;
			alt_valid_q     <= 1'b0;
			apo_latched_q   <= 1'b0;
			apo_time_q      <= '0;
			stable_active_q <= 1'b0;
			stable_start_q  <= '0;
		end else if (take) begin
			phase_q         <= phase_nx;
			apo_latched_q   <= apo_latched_nx;
			apo_time_q      <= apo_time_nx;
			stable_active_q <= stable_active_nx;
			stable_start_q  <= stable_start_nx;
			if (!cls_item.action && phase_q == PH_FLIGHT) begin
				last_alt_q  <= cls_item.altitude_cm;
				alt_valid_q <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cls_ready) begin
			out_valid_q <= cls_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_phase_q  <= phase_encode(phase_nx);
			out_apogee_q <= apo_latched_nx;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_phase       = out_phase_q;
	assign out_apogee_seen = out_apogee_q;

endmodule
